// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file wfm_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error(msg);

// Delayed implication, disabled while rst is high.
`define ASSERT_AFTER2(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##2 (c)) \
      else $error(msg);

`endif

// ===== design/wfm_pkg.sv =====
// Types, constants and the case-fold function of the wildcard file-name matcher.
// No dependencies.
package wfm_pkg;

   localparam int MAX_MASK_LEN = 32;
   localparam int LEN_W        = $clog2(MAX_MASK_LEN + 1);
   localparam int IDX_W        = $clog2(MAX_MASK_LEN);

   typedef logic [1:0]  op_type;
   typedef logic [15:0] char_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [MAX_MASK_LEN-1:0][15:0] mask_vec_type;

   // NFA position state: active positions and star-skip flags
   typedef struct packed {
      logic [MAX_MASK_LEN:0]   active;
      logic [MAX_MASK_LEN-1:0] skip;
   } nfa_state_type;

   // Operation codes
   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_APPEND = 2'd1;
   localparam op_type OP_NAME   = 2'd2;
   localparam op_type OP_END    = 2'd3;

   // Special characters
   localparam char_type CH_STAR  = 16'h002A;
   localparam char_type CH_QUEST = 16'h003F;
   localparam char_type CH_HASH  = 16'h0023;
   localparam char_type CH_DOT   = 16'h002E;
   localparam char_type CH_ZERO  = 16'h0030;
   localparam char_type CH_NINE  = 16'h0039;
   localparam char_type CH_UP_A  = 16'h0041;
   localparam char_type CH_UP_Z  = 16'h005A;
   localparam char_type CASE_OFS = 16'h0020;

   localparam nfa_state_type NFA_START = '{active: (MAX_MASK_LEN + 1)'(1), skip: '0};

   // ASCII A-Z to a-z, everything else unchanged
   function automatic char_type fold(input char_type c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
   endfunction

endpackage

// ===== design/wildcard_filename_matcher.sv =====
// Wildcard file-name matcher: input register, combinational NFA update, result register.
// Depends on wfm_pkg and wfm_nfa.
// An end-of-name beat passes the input register and then the result register, which drives rsp_valid.
// Throughput: one beat per cycle; an end beat waits only while a stalled result holds.
// Reset (synchronous): mask length, overflow flag and extended mode cleared,
// only position 0 active; the mask store is not cleared.
module wildcard_filename_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wfm_pkg::op_type   req_op,
   input  wfm_pkg::char_type req_char_code,
   input  logic              req_has_extension,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_matched,
   output logic              rsp_mask_overflow,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import wfm_pkg::*;

   // input stage
   logic          in_vld_ff;
   op_type        in_op_ff;
   char_type      in_char_ff;
   logic          in_ext_ff;

   // block state
   mask_vec_type  store_ff;
   len_type       len_ff, len_in;
   logic          ovf_ff, ovf_in;
   nfa_state_type nfa_ff, nfa_in;
   logic          ext_mode_ff;

   // result stage
   logic          rsp_vld_ff, rsp_vld_in;
   logic          rsp_match_ff;
   logic          rsp_ovf_ff;

   nfa_state_type nfa_next;
   logic          hit;
   logic          rsp_free;
   logic          fire;
   logic          store_we;
   logic          is_end;

   wfm_nfa u_nfa (
      .mask_i     (store_ff),
      .len_i      (len_ff),
      .state_i    (nfa_ff),
      .char_i     (in_char_ff),
      .ext_mode_i (ext_mode_ff),
      .has_ext_i  (in_ext_ff),
      .state_o    (nfa_next),
      .hit_o      (hit)
   );

   // handshake
   assign is_end    = in_op_ff == OP_END;
   assign rsp_free  = ~rsp_vld_ff | ~rsp_stall;
   assign fire      = in_vld_ff & (~is_end | rsp_free);
   assign req_stall = in_vld_ff & ~fire;
   assign csr_ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (~req_stall) begin
         in_vld_ff <= req_valid;
      end
      if (~req_stall && req_valid) begin
         in_op_ff   <= req_op;
         in_char_ff <= req_char_code;
         in_ext_ff  <= req_has_extension;
      end
   end

   // next state per op
   always_comb begin
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      nfa_in     = nfa_ff;
      store_we   = 1'b0;
      rsp_vld_in = rsp_vld_ff & rsp_stall;
      if (fire) begin
         case (in_op_ff)
            OP_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
               nfa_in = NFA_START;
            end
            OP_APPEND: begin
               if (len_ff < LEN_W'(MAX_MASK_LEN)) begin
                  store_we = 1'b1;
                  len_in   = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               nfa_in = NFA_START;
            end
            OP_NAME: begin
               nfa_in = nfa_next;
            end
            OP_END: begin
               rsp_vld_in = 1'b1;
               nfa_in     = NFA_START;
            end
            default: begin
               nfa_in = NFA_START;
            end
         endcase
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         ovf_ff      <= 1'b0;
         nfa_ff      <= NFA_START;
         ext_mode_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         nfa_ff     <= nfa_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_valid && csr_ready) begin
            ext_mode_ff <= csr_data;
         end
      end
      if (fire && is_end) begin
         rsp_match_ff <= hit;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // mask store, folded at write time
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[len_ff[IDX_W-1:0]] <= fold(in_char_ff);
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_matched       = rsp_match_ff;
   assign rsp_mask_overflow = rsp_ovf_ff;

endmodule

// ===== design/wfm_nfa.sv =====
// One NFA step of the wildcard matcher: next position state and end-of-name hit.
// Depends on wfm_pkg.
module wfm_nfa (
   input  wfm_pkg::mask_vec_type  mask_i,
   input  wfm_pkg::len_type       len_i,
   input  wfm_pkg::nfa_state_type state_i,
   input  wfm_pkg::char_type      char_i,
   input  logic                   ext_mode_i,
   input  logic                   has_ext_i,
   output wfm_pkg::nfa_state_type state_o,
   output logic                   hit_o
);
   import wfm_pkg::*;

   localparam int N = MAX_MASK_LEN;

   char_type       cf;
   logic           is_digit;
   logic [N-1:0]   in_mask;   // position below mask length
   logic [N+2:0]   at_len;    // position equals mask length
   logic [N-1:0]   acc;
   logic [N+1:0]   star;
   logic [N:0]     dot;
   logic [N-1:0]   prop;      // star that does not accept: passes the char on
   logic [N-1:0]   src;
   logic [N-1:0]   gen;
   logic [N-1:0]   sum;
   logic [N-1:0]   carry;
   logic [N-1:0]   tried;
   logic [N+1:0]   ed;
   logic [N:0]     start;
   logic [N:0]     end_ok;

   // per-position classification of the stored mask against this char
   always_comb begin
      cf       = fold(char_i);
      is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
      star     = '0;
      dot      = '0;
      for (int q = 0; q < N; q++) begin
         in_mask[q] = int'(len_i) > q;
         acc[q]  = in_mask[q] & ((mask_i[q] == cf) || (mask_i[q] == CH_QUEST) ||
                   (ext_mode_i && (mask_i[q] == CH_HASH) && is_digit));
         star[q] = in_mask[q] & (mask_i[q] == CH_STAR);
         dot[q]  = in_mask[q] & (mask_i[q] == CH_DOT);
         prop[q] = star[q] & ~acc[q];
      end
      for (int q = 0; q <= N + 2; q++) begin
         at_len[q] = int'(len_i) == q;
      end
   end

   // star runs forward a char like a carry chain: one add resolves it
   always_comb begin
      src[0] = state_i.active[0];
      for (int q = 1; q < N; q++) begin
         src[q] = state_i.active[q] | state_i.skip[q-1];
      end
      gen   = src & prop;
      sum   = prop + gen;
      carry = sum ^ prop ^ gen;
      tried = (src | carry) & in_mask;
   end

   // next state
   always_comb begin
      state_o.active = {tried & acc, 1'b0};
      state_o.skip   = (state_i.skip & in_mask) | (tried & prop);
   end

   // end of name: rest of mask empty after one optional star,
   // or "." / ".*" when the name has no extension
   always_comb begin
      for (int q = 0; q <= N + 1; q++) begin
         ed[q] = at_len[q];
         if (q <= N) begin
            ed[q] = ed[q] | (~has_ext_i & dot[q] &
                             (at_len[q+1] | (at_len[q+2] & star[q+1])));
         end
      end
      start[0] = state_i.active[0];
      for (int p = 1; p <= N; p++) begin
         start[p] = state_i.active[p] | state_i.skip[p-1];
      end
      for (int p = 0; p <= N; p++) begin
         end_ok[p] = star[p] ? ed[p+1] : ed[p];
      end
      hit_o = |(start & end_ok);
   end

endmodule

// ===== design/wfm_checker.sv =====
// Port-level checks for wildcard_filename_matcher, bound to the top level.
// Depends on wfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wfm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input wfm_pkg::op_type   req_op,
   input wfm_pkg::char_type req_char_code,
   input logic              req_has_extension,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_matched,
   input logic              rsp_mask_overflow,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              csr_data
);
   import wfm_pkg::*;

   logic req_beat;
   logic end_beat;
   logic other_beat;

   assign req_beat   = req_valid & ~req_stall;
   assign end_beat   = req_beat & (req_op == OP_END);
   assign other_beat = req_beat & (req_op != OP_END);

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped under stall")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_matched) && $stable(rsp_mask_overflow), "rsp payload changed under stall")

   // reset empties the result register
   `ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")

   // an end-of-name beat that finds the output empty yields a valid result
   `ASSERT_NEXT(a_end_result, clock, reset, end_beat ##1 !rsp_valid, rsp_valid, "end beat gave no result")

   // other beats produce no result
   `ASSERT_NEXT(a_no_spurious, clock, reset, other_beat ##1 !rsp_valid, !rsp_valid, "result without end beat")

endmodule

bind wildcard_filename_matcher wfm_checker u_wfm_checker (.*);

// ===== bench/tb_wildcard_filename_matcher.sv =====
// Self-checking bench for the wildcard file-name matcher: directed and random beats.
// Depends on wfm_pkg and the wildcard_filename_matcher RTL.
// An in-bench NFA model predicts each end-of-name verdict, and a monitor checks them in order.
module tb_wildcard_filename_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   import wfm_pkg::*;

   localparam int RUN_LIMIT_NS = 1_500_000;

   typedef struct {
      logic matched;
      logic overflow;
   } verdict_type;

   // DUT ports
   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   op_type   req_op = OP_CLEAR;
   char_type req_char_code = '0;
   logic     req_has_extension = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic     rsp_matched;
   logic     rsp_mask_overflow;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   logic     csr_data = 1'b0;

   // Matcher model state
   char_type                mask_mem [MAX_MASK_LEN];
   int                      mask_len;
   logic [MAX_MASK_LEN:0]   live_pos;
   logic [MAX_MASK_LEN-1:0] star_pend;
   logic                    mask_ovf;
   logic                    ext_mode;

   verdict_type pending_verdicts [$];
   int          beats_sent = 0;
   int          mismatches = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          stall_left = 0;

   wildcard_filename_matcher uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_char_code     (req_char_code),
      .req_has_extension (req_has_extension),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_matched       (rsp_matched),
      .rsp_mask_overflow (rsp_mask_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Matcher model
   // ---------------------------------------------------------------
   function automatic char_type to_lower(input char_type c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? char_type'(c + CASE_OFS) : c;
   endfunction

   function automatic logic char_accepts(input char_type mc, input char_type c);
      if (to_lower(mc) == to_lower(c) || mc == CH_QUEST) return 1'b1;
      return ext_mode && mc == CH_HASH && c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void restart_name();
      live_pos  = '0;
      star_pend = '0;
      live_pos[0] = 1'b1;
   endfunction

   // Push one name char through position p, walking across stars
   function automatic void feed_pos(input int p, input char_type c,
                                    inout logic [MAX_MASK_LEN:0] nxt_live,
                                    inout logic [MAX_MASK_LEN-1:0] nxt_star);
      int q;
      q = p;
      while (q < mask_len) begin
         if (char_accepts(mask_mem[q], c)) begin
            nxt_live[q+1] = 1'b1;
            return;
         end
         if (mask_mem[q] != CH_STAR) return;
         nxt_star[q] = 1'b1;
         q++;
      end
   endfunction

   // Rest of mask from p is empty, maybe after one star; "." or ".*" without extension
   function automatic logic tail_ok(input int p, input logic has_ext);
      int q;
      q = p;
      if (q < mask_len && mask_mem[q] == CH_STAR) q++;
      if (!has_ext && q < mask_len && mask_mem[q] == CH_DOT)
         return (q + 1 == mask_len) ||
                (q + 2 == mask_len && mask_mem[q+1] == CH_STAR);
      return q == mask_len;
   endfunction

   function automatic void advance_matcher(input op_type op, input char_type c,
                                           input logic has_ext);
      logic [MAX_MASK_LEN:0]   nxt_live;
      logic [MAX_MASK_LEN-1:0] nxt_star;
      verdict_type             v;
      case (op)
         OP_CLEAR: begin
            mask_len = 0;
            mask_ovf = 1'b0;
            restart_name();
         end
         OP_APPEND: begin
            if (mask_len < MAX_MASK_LEN) begin
               mask_mem[mask_len] = c;
               mask_len++;
            end else begin
               mask_ovf = 1'b1;
            end
            restart_name();
         end
         OP_NAME: begin
            nxt_live = '0;
            nxt_star = '0;
            for (int m = 0; m <= mask_len; m++)
               if (live_pos[m]) feed_pos(m, c, nxt_live, nxt_star);
            for (int m = 0; m < mask_len; m++)
               if (star_pend[m]) begin
                  nxt_star[m] = 1'b1;
                  feed_pos(m + 1, c, nxt_live, nxt_star);
               end
            live_pos  = nxt_live;
            star_pend = nxt_star;
         end
         default: begin
            v.matched = 1'b0;
            for (int m = 0; m <= mask_len; m++)
               if (live_pos[m] && tail_ok(m, has_ext)) v.matched = 1'b1;
            for (int m = 0; m < mask_len; m++)
               if (star_pend[m] && tail_ok(m + 1, has_ext)) v.matched = 1'b1;
            v.overflow = mask_ovf;
            pending_verdicts = {pending_verdicts, v};
            restart_name();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Idle / stall shaping: mostly short, a few long
   // ---------------------------------------------------------------
   function automatic int pick_idle_len();
      if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_stall = 1'b1;
         stall_left = pick_idle_len() - 1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result beat with no verdict outstanding");
         end else begin
            v = pending_verdicts.pop_front();
            if (rsp_matched !== v.matched)
               report_mismatch($sformatf("matched %b, want %b", rsp_matched, v.matched));
            if (rsp_mask_overflow !== v.overflow)
               report_mismatch($sformatf("mask_overflow %b, want %b",
                                         rsp_mask_overflow, v.overflow));
         end
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   task automatic send_beat(input op_type op, input char_type c, input logic has_ext);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? pick_idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         = 1'b1;
      req_op            = op;
      req_char_code     = c;
      req_has_extension = has_ext;
      do @(posedge clock); while (req_stall);
      advance_matcher(op, c, has_ext);
      beats_sent++;
   endtask

   // Stop input, let every verdict arrive, then allow the pipeline to settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ext_mode(input logic v);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      ext_mode = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Random content
   // ---------------------------------------------------------------
   function automatic char_type pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return CH_STAR;
      if (r < 18) return CH_QUEST;
      if (r < 24) return CH_HASH;
      if (r < 32) return CH_DOT;
      if (r < 52) return char_type'(16'h0061 + $urandom_range(0, 4));
      if (r < 67) return char_type'(CH_UP_A + $urandom_range(0, 4));
      if (r < 80) return char_type'(CH_ZERO + $urandom_range(0, 9));
      if (r < 88) begin
         // fold and digit boundaries
         case ($urandom_range(0, 7))
            0: return char_type'(CH_UP_A - 1);
            1: return char_type'(CH_UP_Z + 1);
            2: return CH_UP_Z;
            3: return char_type'(CH_UP_Z + CASE_OFS);
            4: return char_type'(CH_ZERO - 1);
            5: return char_type'(CH_NINE + 1);
            6: return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return char_type'($urandom);
   endfunction

   task automatic load_random_mask();
      int len;
      if ($urandom_range(0, 9) < 7) send_beat(OP_CLEAR, char_type'($urandom), 1'($urandom));
      len = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 8) : $urandom_range(28, 36);
      repeat (len) send_beat(OP_APPEND, pick_char(), 1'($urandom));
   endtask

   // Name char, now and then preceded by a mask edit that restarts the name
   task automatic name_char(input char_type c);
      if ($urandom_range(0, 49) == 0)
         send_beat($urandom_range(0, 1) ? OP_APPEND : OP_CLEAR, pick_char(), 1'($urandom));
      send_beat(OP_NAME, c, 1'($urandom));
   endtask

   // Mostly names shaped after the current mask, with occasional corruption
   task automatic send_random_name();
      char_type snap [MAX_MASK_LEN];
      int       n;
      char_type c;
      n = mask_len;
      for (int k = 0; k < n; k++) snap[k] = mask_mem[k];
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < n; k++) begin
            c = snap[k];
            if (c == CH_STAR) begin
               repeat ($urandom_range(0, 3)) name_char(pick_char());
            end else begin
               if (c == CH_QUEST)
                  c = pick_char();
               else if (c == CH_HASH && $urandom_range(0, 1))
                  c = char_type'(CH_ZERO + $urandom_range(0, 9));
               else if (((c >= CH_UP_A && c <= CH_UP_Z) ||
                         (c >= CH_UP_A + CASE_OFS && c <= CH_UP_Z + CASE_OFS)) &&
                        $urandom_range(0, 1))
                  c = c ^ CASE_OFS;
               if ($urandom_range(0, 19) == 0) c = pick_char();
               name_char(c);
            end
            if ($urandom_range(0, 29) == 0) break;
         end
         if ($urandom_range(0, 9) == 0) name_char(pick_char());
      end else begin
         repeat ($urandom_range(0, 8)) name_char(pick_char());
      end
      send_beat(OP_END, char_type'($urandom), 1'($urandom));
   endtask

   task automatic run_random(input int n);
      int stop;
      int r;
      stop = beats_sent + n;
      while (beats_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            load_random_mask();
         else if (r < 92)
            send_random_name();
         else
            send_beat(op_type'($urandom_range(0, 3)), char_type'($urandom), 1'($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      req_gap_pct   = 10;
      rsp_stall_pct = 10;
      write_ext_mode(1'b0);
      // empty mask, empty name
      send_beat(OP_END, 16'hFFFF, 1'b1);
      // "A*.#" with '#' literal, then as digit class
      send_beat(OP_CLEAR, 16'h0000, 1'b0);
      send_beat(OP_APPEND, CH_UP_A, 1'b0);
      send_beat(OP_APPEND, CH_STAR, 1'b1);
      send_beat(OP_APPEND, CH_DOT, 1'b0);
      send_beat(OP_APPEND, CH_HASH, 1'b1);
      send_beat(OP_NAME, char_type'(CH_UP_A + CASE_OFS), 1'b1);
      send_beat(OP_NAME, CH_STAR, 1'b0);
      send_beat(OP_NAME, CH_DOT, 1'b1);
      send_beat(OP_NAME, char_type'(CH_ZERO + 7), 1'b0);
      send_beat(OP_END, 16'h0000, 1'b1);
      write_ext_mode(1'b1);
      send_beat(OP_NAME, CH_UP_A, 1'b0);
      send_beat(OP_NAME, CH_DOT, 1'b0);
      send_beat(OP_NAME, CH_NINE, 1'b1);
      send_beat(OP_END, 16'h0000, 1'b1);
      // code zero in mask and name, "?.*" tail without extension
      send_beat(OP_CLEAR, 16'hFFFF, 1'b1);
      send_beat(OP_APPEND, 16'h0000, 1'b0);
      send_beat(OP_APPEND, CH_QUEST, 1'b0);
      send_beat(OP_APPEND, CH_DOT, 1'b0);
      send_beat(OP_APPEND, CH_STAR, 1'b0);
      send_beat(OP_NAME, 16'h0000, 1'b0);
      send_beat(OP_NAME, 16'hFFFF, 1'b1);
      send_beat(OP_END, 16'hFFFF, 1'b0);
      // one-char name, shorter than the mask, then empty name against it
      send_beat(OP_NAME, 16'hFFFF, 1'b0);
      send_beat(OP_END, 16'h0000, 1'b1);
      send_beat(OP_END, 16'h0000, 1'b0);
   endtask

   task automatic test_streaming();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      write_ext_mode(1'b0);
      run_random(500);
   endtask

   task automatic test_backpressure();
      req_gap_pct   = 40;
      rsp_stall_pct = 50;
      write_ext_mode(1'b1);
      run_random(600);
   endtask

   task automatic test_mixed();
      req_gap_pct   = 15;
      rsp_stall_pct = 20;
      write_ext_mode(1'b1);
      run_random(350);
      write_ext_mode(1'b0);
      run_random(350);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      mask_len = 0;
      mask_ovf = 1'b0;
      ext_mode = 1'b0;
      restart_name();
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_streaming();
      test_backpressure();
      test_mixed();

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
